@@ design/ffha_pkg.sv @@
package ffha_pkg;

	localparam int unsigned GRANULE_BYTES = 16;
	localparam int unsigned HEADER_BYTES  = 16;
	localparam int unsigned GR_SHIFT      = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_HEAP_START = 1'b0;
	localparam logic CFG_HEAP_END   = 1'b1;

	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_FREE = 2'd1,
		TAG_USED = 2'd2
	} tag_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NULL    = 2'd1,
		ST_OOM     = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef struct packed {
		logic    clear_step;
		logic    accept;
		logic    start_walk;
		logic    walk_step;
		logic    hit;
		logic    wr_split;
		logic    wr_cur;
		logic    wr_prev;
		logic    rd_free;
		logic    wr_free;
		logic    set_status;
		status_t status;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic req_zero;
		logic rel_zero;
		logic head_valid;
		logic fits;
		logic has_next;
		logic split;
		logic addr_ok;
		logic tag_used;
		logic clear_last;
	} dp_stat_t;

endpackage

@@ design/ffha_ctrl.sv @@
module ffha_ctrl import ffha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  logic     cfg_fire,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_START  = 10'b0000000100,
		S_WALK   = 10'b0000001000,
		S_WSPLIT = 10'b0000010000,
		S_WCUR   = 10'b0000100000,
		S_WPREV  = 10'b0001000000,
		S_FCHK   = 10'b0010000000,
		S_FWR    = 10'b0100000000,
		S_RESULT = 10'b1000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_START;
				end
			end
			S_START: begin
				if (!stat.is_free) begin
					if (stat.req_zero) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NULL;
						state_nxt      = S_RESULT;
					end else if (!stat.head_valid) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_OOM;
						state_nxt      = S_RESULT;
					end else begin
						cmd.start_walk = 1'b1;
						state_nxt      = S_WALK;
					end
				end else begin
					if (stat.rel_zero) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NULL;
						state_nxt      = S_RESULT;
					end else if (!stat.addr_ok) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_BADFREE;
						state_nxt      = S_RESULT;
					end else begin
						cmd.rd_free = 1'b1;
						state_nxt   = S_FCHK;
					end
				end
			end
			S_WALK: begin
				if (stat.fits) begin
					cmd.hit   = 1'b1;
					state_nxt = stat.split ? S_WSPLIT : S_WCUR;
				end else if (stat.has_next) begin
					cmd.walk_step = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_OOM;
					state_nxt      = S_RESULT;
				end
			end
			S_WSPLIT: begin
				cmd.wr_split = 1'b1;
				state_nxt    = S_WCUR;
			end
			S_WCUR: begin
				cmd.wr_cur = 1'b1;
				state_nxt  = S_WPREV;
			end
			S_WPREV: begin
				cmd.wr_prev    = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = ST_OK;
				state_nxt      = S_RESULT;
			end
			S_FCHK: begin
				if (stat.tag_used) begin
					state_nxt = S_FWR;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_BADFREE;
					state_nxt      = S_RESULT;
				end
			end
			S_FWR: begin
				cmd.wr_free    = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = ST_OK;
				state_nxt      = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
		// a register write restarts the clearing pass
		if (cfg_fire) state_nxt = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cfg_fire |=> state_q == S_START)
		else $error("accepted item did not start");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> state_q == S_CLEAR)
		else $error("register write did not restart clearing");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESULT && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("result not presented");

endmodule

@@ design/ffha_dp.sv @@
module ffha_dp import ffha_pkg::*; #(
	parameter int unsigned HEAP_GRANULES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_fire,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        op,
	input  logic [16:0] req_bytes,
	input  logic [31:0] release_addr,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [31:0] payload_addr,
	output logic [1:0]  status,
	output logic [16:0] used_bytes,
	output logic [16:0] free_bytes,
	output logic [31:0] total_bytes
);

	localparam int unsigned GW        = $clog2(HEAP_GRANULES);
	localparam int unsigned WIN_BYTES = HEAP_GRANULES * GRANULE_BYTES;
	localparam int unsigned WBW       = $clog2(WIN_BYTES + 1);
	localparam int unsigned SZW       = (WBW > 18) ? WBW : 18;
	localparam int unsigned SPW       = ((GW > 14) ? GW : 14) + 2;

	typedef struct packed {
		tag_t            tag;
		logic [SZW-1:0]  size;
		logic [GW-1:0]   next;
		logic            has_next;
	} hdr_t;

	hdr_t hdr_mem [HEAP_GRANULES];
	hdr_t rd_q;

	logic [31:0]    heap_start_q, heap_end_q;
	logic [32:0]    win_base_q;
	logic [33:0]    eclip_q;
	logic           heap_ok_q;
	logic [SZW-1:0] size0_q;

	logic           op_q;
	logic [16:0]    req_q;
	logic [31:0]    rel_q;

	logic [GW-1:0]  clr_cnt_q;
	logic [GW-1:0]  head_q;
	logic           head_valid_q;
	logic [16:0]    used_q, free_q;

	logic [GW-1:0]  cur_q, prev_q, sp_q;
	logic           has_prev_q, split_q;
	hdr_t           prev_ent_q, hit_ent_q;

	status_t        res_status_q;
	logic [31:0]    res_addr_q;

	logic [31:0]    out_addr_q, out_total_q;
	status_t        out_status_q;
	logic [16:0]    out_used_q, out_free_q;

	// rounded request and split check
	logic [17:0]    req_ext, rsize;
	logic [SZW-1:0] rsize_w, left, final_size;
	logic [SPW-1:0] sp_sum;
	logic           fits, split;

	assign req_ext = {1'b0, req_q} + 18'(GRANULE_BYTES - 1);
	assign rsize   = (req_ext >> GR_SHIFT) << GR_SHIFT;
	assign rsize_w = SZW'(rsize);
	assign fits    = rd_q.size >= rsize_w;
	assign left    = rd_q.size - rsize_w;
	assign sp_sum  = SPW'(cur_q) + SPW'(HEADER_BYTES >> GR_SHIFT) + SPW'(rsize >> GR_SHIFT);
	assign split   = (left > SZW'(HEADER_BYTES + GRANULE_BYTES))
		&& (sp_sum < SPW'(HEAP_GRANULES));
	assign final_size = split_q ? rsize_w : hit_ent_q.size;

	logic [GW-1:0] new_next;
	logic          new_has;
	assign new_next = split_q ? sp_q : hit_ent_q.next;
	assign new_has  = split_q | hit_ent_q.has_next;

	// free address check
	logic [33:0] lo;
	logic [34:0] diff;
	logic [30:0] diff_hi;
	logic        addr_ok;
	assign lo      = {1'b0, win_base_q} + 34'(HEADER_BYTES);
	assign diff    = {3'b000, rel_q} - {1'b0, lo};
	assign diff_hi = diff[34:GR_SHIFT];
	assign addr_ok = heap_ok_q && !diff[34] && (diff[GR_SHIFT-1:0] == '0)
		&& (diff_hi < 31'(HEAP_GRANULES));

	assign stat.is_free    = (op_q == OP_FREE);
	assign stat.req_zero   = (req_q == '0);
	assign stat.rel_zero   = (rel_q == '0);
	assign stat.head_valid = head_valid_q;
	assign stat.fits       = fits;
	assign stat.has_next   = rd_q.has_next;
	assign stat.split      = split;
	assign stat.addr_ok    = addr_ok;
	assign stat.tag_used   = (rd_q.tag == TAG_USED);
	assign stat.clear_last = (clr_cnt_q == '0);

	// memory ports
	logic [GW-1:0] rd_addr, wr_addr;
	logic          we;
	hdr_t          wd;

	always_comb begin
		priority if (cmd.start_walk) rd_addr = head_q;
		else if (cmd.walk_step) rd_addr = rd_q.next;
		else if (cmd.rd_free) rd_addr = diff_hi[GW-1:0];
		else rd_addr = cur_q;
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = cur_q;
		wd      = '0;
		priority if (cmd.clear_step) begin
			we      = 1'b1;
			wr_addr = clr_cnt_q;
			if (clr_cnt_q == '0 && heap_ok_q) begin
				wd.tag  = TAG_FREE;
				wd.size = size0_q;
			end else begin
				wd.tag = TAG_NONE;
			end
		end else if (cmd.wr_split) begin
			we          = 1'b1;
			wr_addr     = sp_q;
			wd.tag      = TAG_FREE;
			wd.size     = hit_ent_q.size - rsize_w - SZW'(HEADER_BYTES);
			wd.next     = hit_ent_q.next;
			wd.has_next = hit_ent_q.has_next;
		end else if (cmd.wr_cur) begin
			we      = 1'b1;
			wd.tag  = TAG_USED;
			wd.size = final_size;
		end else if (cmd.wr_prev) begin
			we          = has_prev_q;
			wr_addr     = prev_q;
			wd          = prev_ent_q;
			wd.next     = new_next;
			wd.has_next = new_has;
		end else if (cmd.wr_free) begin
			we          = 1'b1;
			wd.tag      = TAG_FREE;
			wd.size     = rd_q.size;
			wd.next     = head_q;
			wd.has_next = head_valid_q;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) hdr_mem[wr_addr] <= wd;
		rd_q <= hdr_mem[rd_addr];
	end

	// window geometry registers win_base_q, then eclip_q, then size0_q and heap_ok_q
	logic [32:0] start_up;
	logic [33:0] lim;
	assign start_up = {1'b0, heap_start_q} + 33'(GRANULE_BYTES - 1);
	assign lim      = {1'b0, win_base_q} + 34'(WIN_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q <= 32'd0;
			heap_end_q   <= 32'd65536;
			clr_cnt_q    <= GW'(HEAP_GRANULES - 1);
			heap_ok_q    <= 1'b0;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			used_q       <= '0;
			free_q       <= '0;
			has_prev_q   <= 1'b0;
			split_q      <= 1'b0;
		end else begin
			heap_ok_q <= ({1'b0, win_base_q} + 34'(HEADER_BYTES)) < eclip_q;
			if (cfg_fire) begin
				if (cfg_index == CFG_HEAP_START) heap_start_q <= cfg_data;
				else heap_end_q <= cfg_data;
				clr_cnt_q <= GW'(HEAP_GRANULES - 1);
			end else if (cmd.clear_step && clr_cnt_q != '0) begin
				clr_cnt_q <= clr_cnt_q - 1'b1;
			end
			if (cmd.clear_step && clr_cnt_q == '0) begin
				head_q       <= '0;
				head_valid_q <= heap_ok_q;
				used_q       <= '0;
				// a window too small for one block leaves nothing free
				free_q       <= heap_ok_q ? size0_q[16:0] : 17'd0;
			end
			if (cmd.start_walk) has_prev_q <= 1'b0;
			if (cmd.walk_step) has_prev_q <= 1'b1;
			if (cmd.hit) split_q <= split;
			if (cmd.wr_split) free_q <= free_q - 17'(HEADER_BYTES);
			if (cmd.wr_cur) begin
				used_q <= used_q + final_size[16:0];
				free_q <= free_q - final_size[16:0];
			end
			if (cmd.wr_prev && !has_prev_q) begin
				head_q       <= new_next;
				head_valid_q <= new_has;
			end
			if (cmd.wr_free) begin
				used_q       <= used_q - rd_q.size[16:0];
				free_q       <= free_q + rd_q.size[16:0];
				head_q       <= cur_q;
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_base_q <= start_up & ~33'(GRANULE_BYTES - 1);
		eclip_q    <= ({2'b00, heap_end_q} > lim) ? lim : {2'b00, heap_end_q};
		size0_q    <= SZW'(eclip_q - {1'b0, win_base_q} - 34'(HEADER_BYTES));
		if (cmd.accept) begin
			op_q       <= op;
			req_q      <= req_bytes;
			rel_q      <= release_addr;
			res_addr_q <= '0;
		end
		if (cmd.start_walk) cur_q <= head_q;
		if (cmd.walk_step) begin
			prev_q     <= cur_q;
			prev_ent_q <= rd_q;
			cur_q      <= rd_q.next;
		end
		if (cmd.rd_free) cur_q <= diff_hi[GW-1:0];
		if (cmd.hit) begin
			hit_ent_q <= rd_q;
			sp_q      <= sp_sum[GW-1:0];
		end
		if (cmd.wr_prev) begin
			res_addr_q <= 32'(win_base_q + (33'(cur_q) << GR_SHIFT) + 33'(HEADER_BYTES));
		end
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
			out_used_q   <= used_q;
			out_free_q   <= free_q;
			out_total_q  <= heap_end_q - heap_start_q;
		end
	end

	assign payload_addr = out_addr_q;
	assign status       = out_status_q;
	assign used_bytes   = out_used_q;
	assign free_bytes   = out_free_q;
	assign total_bytes  = out_total_q;

	a_clear_end_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step && clr_cnt_q == '0 && !cfg_fire |=> used_q == '0 && head_q == '0)
		else $error("clearing pass left stale counters");

	a_free_tag_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_free |-> rd_q.tag == TAG_USED)
		else $error("release of a block that is not allocated");

	a_split_marked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_split |-> split_q)
		else $error("split header written without a split");

endmodule

@@ design/first_fit_heap_allocator.sv @@
// channel   signals                                         direction
// input     in_valid, in_ready, op, req_bytes, release_addr  in, ready out
// result    out_valid, out_ready, payload_addr, status,      out, ready in
//           used_bytes, free_bytes, total_bytes
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        in, ready out
//
// an allocate walks the free list, then writes the split header (on a split), its own
// header and the link of the previous entry or list head (no writes when it runs out
// of memory); the walk rate is set by the single registered read port of the header store
// a free reads the block's header, checks that it is used and writes it back free as
// the new list head; a null or other rejected item writes nothing
// after reset and after every register write a clearing pass sweeps all HEAP_GRANULES
// headers; no item is accepted meanwhile, register writes are taken and restart it
// a finished result waits in the output register while the next item is accepted
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int unsigned HEAP_GRANULES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [16:0] req_bytes,
	input  logic [31:0] release_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] payload_addr,
	output logic [1:0]  status,
	output logic [16:0] used_bytes,
	output logic [16:0] free_bytes,
	output logic [31:0] total_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_fire  (cfg_fire),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffha_dp #(.HEAP_GRANULES(HEAP_GRANULES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_fire     (cfg_fire),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.req_bytes    (req_bytes),
		.release_addr (release_addr),
		.cmd          (cmd),
		.stat         (stat),
		.payload_addr (payload_addr),
		.status       (status),
		.used_bytes   (used_bytes),
		.free_bytes   (free_bytes),
		.total_bytes  (total_bytes)
	);

endmodule
